// ===== src/fta_pkg.sv =====
// Shared types and constants for the frame table allocator.
// Used by fta_ctrl, fta_datapath and frame_table_allocator; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fta_pkg;

    localparam int FRAMES = 64;
    localparam int IDX_W  = $clog2(FRAMES);
    localparam int CNT_W  = $clog2(FRAMES + 1);
    localparam int PID_W  = 8;
    localparam int ADDR_W = 32;
    localparam int FC_W   = 7;
    localparam int PSL_W  = 5;
    localparam int FNUM_W = 6;
    localparam int TOT_W  = 7;

    localparam logic [PID_W-1:0] NO_OWNER = 8'hFF;

    localparam logic CFG_FRAME_COUNT = 1'b0;
    localparam logic CFG_PAGE_LOG2   = 1'b1;

    localparam logic [FC_W-1:0]  FRAME_COUNT_RST = 7'd64;
    localparam logic [PSL_W-1:0] PAGE_LOG2_RST   = 5'd6;

    typedef enum logic [2:0] {
        ACT_RELEASE = 3'd0,
        ACT_COUNT   = 3'd1,
        ACT_FIND    = 3'd2,
        ACT_CLAIM   = 3'd3,
        ACT_LOCATE  = 3'd4
    } t_action;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CLAIM,
        ST_LOC,
        ST_LOC_WAIT,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic          is_free;
        logic [PID_W-1:0] owner;
    } t_entry;

    // Controller to datapath.
    typedef struct packed {
        logic load;      // capture the accepted transaction, clear results
        logic scan;      // advance the table sweep
        logic claim_wr;  // write the claimed entry
        logic loc_rd;    // read the located entry
        logic loc_cap;   // capture the located entry
        logic out_load;  // move results to the output register
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        t_action new_action;  // action of the transaction being offered
        t_action action;      // action of the transaction in progress
        logic    scan_done;
        logic    found;
        logic    in_range;
        logic    out_free;
    } t_status;

endpackage

`default_nettype wire

// ===== src/fta_ctrl.sv =====
// Controller state machine of the frame table allocator.
// Depends on fta_pkg; drives fta_datapath through t_cmd.
`timescale 1ns / 1ps
`default_nettype none

module fta_ctrl (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_accept,
    input  fta_pkg::t_status i_status,
    output logic            o_ready,
    output fta_pkg::t_cmd   o_cmd
);
    import fta_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_accept) begin
                    unique case (i_status.new_action) inside
                        ACT_RELEASE, ACT_COUNT, ACT_FIND, ACT_CLAIM: n_state = ST_SCAN;
                        ACT_LOCATE: n_state = ST_LOC;
                        default:    n_state = ST_FINISH;
                    endcase
                end
            end
            ST_SCAN: begin
                if (i_status.scan_done) begin
                    if (i_status.action == ACT_CLAIM && i_status.found) begin
                        n_state = ST_CLAIM;
                    end else begin
                        n_state = ST_FINISH;
                    end
                end
            end
            ST_CLAIM:    n_state = ST_FINISH;
            ST_LOC:      n_state = i_status.in_range ? ST_LOC_WAIT : ST_FINISH;
            ST_LOC_WAIT: n_state = ST_FINISH;
            ST_FINISH: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:     n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.load = i_accept;
            end
            ST_SCAN:     o_cmd.scan     = 1'b1;
            ST_CLAIM:    o_cmd.claim_wr = 1'b1;
            ST_LOC:      o_cmd.loc_rd   = i_status.in_range;
            ST_LOC_WAIT: o_cmd.loc_cap  = 1'b1;
            ST_FINISH:   o_cmd.out_load = i_status.out_free;
            default:     o_ready        = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

// ===== src/fta_datapath.sv =====
// Datapath of the frame table allocator: configuration, frame table memory,
// sweep counter, result and output registers. Depends on fta_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fta_datapath (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_cfg_we,
    input  wire                        i_cfg_index,
    input  wire  [fta_pkg::FC_W-1:0]   i_cfg_data,
    input  wire  [2:0]                 i_action,
    input  wire  [fta_pkg::PID_W-1:0]  i_pid,
    input  wire  [fta_pkg::ADDR_W-1:0] i_address,
    input  fta_pkg::t_cmd              i_cmd,
    input  wire                        i_out_ready,
    output fta_pkg::t_status           o_status,
    output logic                       o_out_valid,
    output logic [fta_pkg::FNUM_W-1:0] o_frame_number,
    output logic                       o_found,
    output logic [fta_pkg::TOT_W-1:0]  o_frame_total,
    output logic [fta_pkg::PID_W-1:0]  o_owner,
    output logic                       o_is_free
);
    import fta_pkg::*;

    // Configuration
    logic [FC_W-1:0]  r_frame_count;
    logic [PSL_W-1:0] r_page_log2;
    logic [CNT_W-1:0] w_active;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count <= FRAME_COUNT_RST;
            r_page_log2   <= PAGE_LOG2_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FRAME_COUNT: r_frame_count <= i_cfg_data;
                CFG_PAGE_LOG2:   r_page_log2   <= i_cfg_data[PSL_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_active = (r_frame_count > FC_W'(FRAMES)) ? CNT_W'(FRAMES)
                                                      : CNT_W'(r_frame_count);

    // Transaction capture
    t_action          r_action;
    logic [PID_W-1:0] r_pid;
    logic [IDX_W-1:0] r_loc_idx;
    logic             r_in_range;
    logic [ADDR_W-1:0] w_frame;
    logic             w_in_range;

    assign w_frame    = i_address >> r_page_log2;
    assign w_in_range = (w_frame < ADDR_W'(w_active));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action   <= t_action'(i_action);
            r_pid      <= i_pid;
            r_loc_idx  <= w_frame[IDX_W-1:0];
            r_in_range <= w_in_range;
        end
    end

    // Frame table: one write and one registered read per cycle; an entry
    // never written since reset reads as free and unowned.
    t_entry           r_mem [FRAMES];
    logic [FRAMES-1:0] r_vld;
    t_entry           r_rd_data;
    logic             r_rd_vld;
    t_entry           w_entry;
    logic [IDX_W-1:0] w_rd_addr;
    logic             w_wr_en;
    logic [IDX_W-1:0] w_wr_addr;
    t_entry           w_wr_data;

    // Sweep
    logic [CNT_W-1:0] r_idx;
    logic [IDX_W-1:0] r_pidx;
    logic             r_pvld;
    logic             w_rd_en;
    logic             w_hit;

    assign w_rd_en   = i_cmd.scan && (r_idx < w_active);
    assign w_rd_addr = i_cmd.loc_rd ? r_loc_idx : r_idx[IDX_W-1:0];
    assign w_entry   = r_rd_vld ? r_rd_data : t_entry'{is_free: 1'b1, owner: NO_OWNER};
    assign w_hit     = i_cmd.scan && r_pvld;

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[w_rd_addr];
        r_rd_vld  <= r_vld[w_rd_addr];
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_wr_en) begin
            r_vld[w_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_pvld <= 1'b0;
        end else if (i_cmd.load) begin
            r_idx  <= '0;
            r_pvld <= 1'b0;
        end else begin
            r_pvld <= w_rd_en;
            if (w_rd_en) begin
                r_idx <= r_idx + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_pidx <= r_idx[IDX_W-1:0];
        end
    end

    // Results
    logic [FNUM_W-1:0] r_fnum;
    logic              r_found;
    logic [TOT_W-1:0]  r_total;
    logic [PID_W-1:0]  r_owner;
    logic              r_free;
    logic              w_match;
    logic              w_release;

    assign w_match   = w_hit && (w_entry.owner == r_pid);
    assign w_release = w_match && (r_action == ACT_RELEASE);

    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_pidx;
        w_wr_data = t_entry'{is_free: 1'b1, owner: NO_OWNER};
        if (w_release) begin
            w_wr_en = 1'b1;
        end else if (i_cmd.claim_wr) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_fnum[IDX_W-1:0];
            w_wr_data = t_entry'{is_free: 1'b0, owner: r_pid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_fnum  <= '0;
            r_found <= 1'b0;
            r_total <= '0;
            r_owner <= (t_action'(i_action) == ACT_LOCATE && !w_in_range) ? NO_OWNER : '0;
            r_free  <= 1'b0;
        end else if (i_cmd.loc_cap) begin
            r_fnum  <= FNUM_W'(r_loc_idx);
            r_found <= 1'b1;
            r_owner <= w_entry.owner;
            r_free  <= w_entry.is_free;
        end else begin
            if (w_match && (r_action == ACT_RELEASE || r_action == ACT_COUNT)) begin
                r_total <= r_total + TOT_W'(1);
            end
            if (w_hit && w_entry.is_free && !r_found &&
                (r_action == ACT_FIND || r_action == ACT_CLAIM)) begin
                r_fnum  <= FNUM_W'(r_pidx);
                r_found <= 1'b1;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_frame_number <= r_fnum;
            o_found        <= r_found;
            o_frame_total  <= r_total;
            o_owner        <= r_owner;
            o_is_free      <= r_free;
        end
    end

    assign o_status.new_action = t_action'(i_action);
    assign o_status.action     = r_action;
    assign o_status.scan_done  = !w_rd_en && !r_pvld;
    assign o_status.found      = r_found;
    assign o_status.in_range   = r_in_range;
    assign o_status.out_free   = !o_out_valid || i_out_ready;

endmodule

`default_nettype wire

// ===== src/frame_table_allocator.sv =====
// Top level of the frame table allocator: stream ports, configuration port.
// Instantiates fta_ctrl and fta_datapath; depends on fta_pkg.
`timescale 1ns / 1ps
`default_nettype none

//  Channel   Direction  Handshake               Payload
//  s_axis    in         i_s_tvalid/o_s_tready   action, pid, address
//  m_axis    out        o_m_tvalid/i_m_tready   frame_number, found, frame_total,
//                                               owner, is_free
//  cfg       in         i_cfg_we (no wait)      0 frame_count, 1 page_size_log2
//
//  Sequencing: release, count and find sweep the active frames of the frame table
//  one entry per cycle through its single read port; claim adds a write of the
//  claimed entry; locate reads one entry (no read when out of range); unused
//  codes go straight to the result.
//  Reset: synchronous, active low; every frame reads free and unowned at once
//  through per-entry valid bits, no clearing pass.
//  Stalls: a finished result waits in the result registers until the output register
//  frees; no new transaction is taken until it has moved there.

module frame_table_allocator (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // Configuration write
    input  wire         i_cfg_we,
    input  wire         i_cfg_index,
    input  wire  [6:0]  i_cfg_data,
    // Input stream
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [47:0] i_s_tdata,   // [2:0] action, [10:3] pid, [42:11] address, zero fill
    // Output stream
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [23:0] o_m_tdata    // [5:0] frame_number, [6] found, [13:7] frame_total,
                                     // [21:14] owner, [22] is_free, zero fill
);
    import fta_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;
    logic    w_accept;

    logic [FNUM_W-1:0] w_frame_number;
    logic              w_found;
    logic [TOT_W-1:0]  w_frame_total;
    logic [PID_W-1:0]  w_owner;
    logic              w_is_free;

    // Accept a transaction only while the controller is idle.
    assign w_accept = i_s_tvalid && o_s_tready;

    fta_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_status (w_status),
        .o_ready  (o_s_tready),
        .o_cmd    (w_cmd)
    );

    fta_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_action       (i_s_tdata[2:0]),
        .i_pid          (i_s_tdata[10:3]),
        .i_address      (i_s_tdata[42:11]),
        .i_cmd          (w_cmd),
        .i_out_ready    (i_m_tready),
        .o_status       (w_status),
        .o_out_valid    (o_m_tvalid),
        .o_frame_number (w_frame_number),
        .o_found        (w_found),
        .o_frame_total  (w_frame_total),
        .o_owner        (w_owner),
        .o_is_free      (w_is_free)
    );

    // Pack result fields, lowest field first, zero fill to a whole byte.
    assign o_m_tdata = {1'b0, w_is_free, w_owner, w_frame_total, w_found, w_frame_number};

endmodule

`default_nettype wire
